// ----- src/isotp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_pkg
// Shared types and constants of the transport reassembly receiver.
// ----------------------------------------------------------------------------
package isotp_pkg;

  localparam int IN_W  = 104;
  localparam int OUT_W = 88;

  localparam logic [2:0] REG_RX_ID       = 3'd0;
  localparam logic [2:0] REG_TX_ID       = 3'd1;
  localparam logic [2:0] REG_BLOCK_SIZE  = 3'd2;
  localparam logic [2:0] REG_SEP_TIME    = 3'd3;
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd4;

  localparam logic [7:0]  BLOCK_SIZE_RST  = 8'd8;
  localparam logic [7:0]  SEP_TIME_RST    = 8'd10;
  localparam logic [15:0] RETRY_LIMIT_RST = 16'd10000;

  localparam logic [3:0] TYPE_SINGLE      = 4'h0;
  localparam logic [3:0] TYPE_FIRST       = 4'h1;
  localparam logic [3:0] TYPE_CONSECUTIVE = 4'h2;

  localparam logic [7:0]  FC_STATUS   = 8'h30;
  localparam logic [2:0]  FC_COUNT    = 3'd3;
  localparam logic [3:0]  SEQ_START   = 4'd1;
  localparam logic [3:0]  MAX_LEN     = 4'd8;
  localparam logic [15:0] RETRY_SAT   = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_CHUNK = 2'd0,
    KIND_FC    = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [28:0] rx_id;
    logic [28:0] tx_id;
    logic [7:0]  block_size;
    logic [7:0]  sep_time;
    logic [15:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0][7:0] data;
    logic [3:0]      data_len;
    logic [28:0]     frame_id;
  } frame_t;

  typedef struct packed {
    logic        receiving;
    logic [11:0] total_length;
    logic [11:0] received_count;
    logic [3:0]  expected_seq;
    logic [15:0] retry_count;
  } rx_state_t;

  typedef struct packed {
    kind_t           kind;
    logic            last;
    logic [6:0][7:0] bytes;
    logic [2:0]      byte_count;
    logic [28:0]     target_id;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
    rx_state_t  nxt;
  } dec_t;

  function automatic result_t make_chunk(logic [6:0][7:0] src, logic [2:0] cnt,
                                         logic last);
    result_t r;
    r = '0;
    r.kind = KIND_CHUNK;
    r.byte_count = cnt;
    r.last = last;
    for (int i = 0; i < 7; i++) begin
      if (i < int'(cnt)) begin
        r.bytes[i] = src[i];
      end
    end
    return r;
  endfunction

endpackage

// ----- src/isotp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module isotp_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [28:0]       cfg_data,
  output isotp_pkg::cfg_t   cfg
);

  isotp_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rx_id       <= '0;
      regs.tx_id       <= '0;
      regs.block_size  <= isotp_pkg::BLOCK_SIZE_RST;
      regs.sep_time    <= isotp_pkg::SEP_TIME_RST;
      regs.retry_limit <= isotp_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        isotp_pkg::REG_RX_ID:       regs.rx_id       <= cfg_data;
        isotp_pkg::REG_TX_ID:       regs.tx_id       <= cfg_data;
        isotp_pkg::REG_BLOCK_SIZE:  regs.block_size  <= cfg_data[7:0];
        isotp_pkg::REG_SEP_TIME:    regs.sep_time    <= cfg_data[7:0];
        isotp_pkg::REG_RETRY_LIMIT: regs.retry_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- src/isotp_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_decode
// Frame decode: results of one frame and the receiver state after it.
// ----------------------------------------------------------------------------
module isotp_decode (
  input  isotp_pkg::frame_t    frame,
  input  isotp_pkg::rx_state_t st,
  input  isotp_pkg::cfg_t      cfg,
  output isotp_pkg::dec_t      dec
);

  logic [3:0]      len;
  logic [7:0]      pci;
  logic [3:0]      ftype;
  logic [3:0]      low_nib;
  logic            foreign;
  logic            timeout;
  logic [15:0]     retry_inc;
  logic            abort;
  logic [6:0][7:0] src1;
  logic [6:0][7:0] src2;
  logic [3:0]      len_m1;
  logic [3:0]      len_m2;
  logic [2:0]      sf_cnt;
  logic [11:0]     ff_total;
  logic [2:0]      ff_cnt;
  logic            ff_done;
  logic [11:0]     cf_rem;
  logic [2:0]      cf_cnt;
  logic [11:0]     cf_rcv;
  logic            cf_done;
  isotp_pkg::result_t fc_res;
  isotp_pkg::result_t abort_res;

  assign len     = (frame.data_len > isotp_pkg::MAX_LEN) ? isotp_pkg::MAX_LEN : frame.data_len;
  assign pci     = frame.data[0];
  assign ftype   = pci[7:4];
  assign low_nib = pci[3:0];
  assign foreign = (frame.frame_id != '0) && (frame.frame_id != cfg.rx_id);
  assign timeout = (frame.frame_id == '0) || (len == 4'd0);

  assign retry_inc = (st.retry_count != isotp_pkg::RETRY_SAT) ?
                     st.retry_count + 16'd1 : st.retry_count;
  assign abort     = retry_inc >= cfg.retry_limit;

  assign src1 = frame.data[7:1];
  assign src2 = {8'd0, frame.data[7:2]};

  assign len_m1 = len - 4'd1;
  assign len_m2 = (len >= 4'd2) ? len - 4'd2 : 4'd0;

  assign sf_cnt = (low_nib < len_m1) ? low_nib[2:0] : len_m1[2:0];

  assign ff_total = {low_nib, frame.data[1]};
  assign ff_cnt   = ({8'd0, len_m2} < ff_total) ? len_m2[2:0] : ff_total[2:0];
  assign ff_done  = {9'd0, ff_cnt} >= ff_total;

  assign cf_rem  = (st.total_length > st.received_count) ?
                   st.total_length - st.received_count : 12'd0;
  assign cf_cnt  = ({8'd0, len_m1} < cf_rem) ? len_m1[2:0] : cf_rem[2:0];
  assign cf_rcv  = st.received_count + {9'd0, cf_cnt};
  assign cf_done = cf_rcv >= st.total_length;

  always_comb begin
    fc_res            = '0;
    fc_res.kind       = isotp_pkg::KIND_FC;
    fc_res.target_id  = cfg.tx_id;
    fc_res.byte_count = isotp_pkg::FC_COUNT;
    fc_res.bytes[0]   = isotp_pkg::FC_STATUS;
    fc_res.bytes[1]   = cfg.block_size;
    fc_res.bytes[2]   = cfg.sep_time;
    abort_res         = '0;
    abort_res.kind    = isotp_pkg::KIND_ABORT;
  end

  always_comb begin
    dec      = '0;
    dec.nxt  = st;
    if (foreign) begin
      dec.n = 2'd0;
    end else if (timeout) begin
      if (st.receiving) begin
        dec.res0 = fc_res;
        dec.n    = 2'd1;
      end
      if (abort) begin
        if (st.receiving) begin
          dec.res1 = abort_res;
          dec.n    = 2'd2;
        end else begin
          dec.res0 = abort_res;
          dec.n    = 2'd1;
        end
        dec.nxt.receiving   = 1'b0;
        dec.nxt.retry_count = '0;
      end else begin
        dec.nxt.retry_count = retry_inc;
      end
    end else if (!st.receiving) begin
      if (ftype == isotp_pkg::TYPE_SINGLE) begin
        if (low_nib != 4'd0 && len > 4'd1) begin
          dec.res0            = isotp_pkg::make_chunk(src1, sf_cnt, 1'b1);
          dec.n               = 2'd1;
          dec.nxt.retry_count = '0;
        end
      end else if (ftype == isotp_pkg::TYPE_FIRST) begin
        dec.res0               = isotp_pkg::make_chunk(src2, ff_cnt, ff_done);
        dec.res1               = fc_res;
        dec.n                  = 2'd2;
        dec.nxt.total_length   = ff_total;
        dec.nxt.received_count = {9'd0, ff_cnt};
        dec.nxt.expected_seq   = isotp_pkg::SEQ_START;
        dec.nxt.receiving      = !ff_done;
      end
    end else if (ftype != isotp_pkg::TYPE_CONSECUTIVE) begin
      dec.res0 = fc_res;
      dec.n    = 2'd1;
    end else if (low_nib != st.expected_seq) begin
      if (abort) begin
        dec.res0            = abort_res;
        dec.n               = 2'd1;
        dec.nxt.receiving   = 1'b0;
        dec.nxt.retry_count = '0;
      end else begin
        dec.nxt.retry_count = retry_inc;
      end
    end else begin
      dec.res0               = isotp_pkg::make_chunk(src1, cf_cnt, cf_done);
      dec.n                  = 2'd1;
      dec.nxt.received_count = cf_rcv;
      dec.nxt.expected_seq   = st.expected_seq + 4'd1;
      dec.nxt.retry_count    = '0;
      dec.nxt.receiving      = !cf_done;
    end
  end

endmodule

// ----- src/isotp_reassembly_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_reassembly_receiver
// Beats pass the input register, then each result the single result register
//   on m_*. Throughput: one frame per cycle while m_tready allows; a frame
//   with two results holds the input register until its second one is loaded.
// Reset (rst, synchronous): registers to defaults, idle, sequence 1, no beats.
// ----------------------------------------------------------------------------
module isotp_reassembly_receiver (
  input  logic                         clk,
  input  logic                         rst,
  // tdata: frame_id, data_len, byte0..byte7, zero pad
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [isotp_pkg::IN_W-1:0]   s_tdata,
  // tdata: target_id, byte_count, out_byte0..out_byte6
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [isotp_pkg::OUT_W-1:0]  m_tdata,
  // tuser: result_kind
  output logic [1:0]                   m_tuser,
  output logic                         m_tlast,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [28:0]                  cfg_data
);

  isotp_pkg::cfg_t      cfg;
  isotp_pkg::frame_t    frame;
  isotp_pkg::rx_state_t st;
  isotp_pkg::dec_t      dec;
  isotp_pkg::result_t   res;
  isotp_pkg::result_t   sel;
  logic                 in_valid;
  logic                 phase;
  logic                 out_free;
  logic                 load;
  logic                 final_beat;
  logic                 consume;

  isotp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  isotp_decode u_decode (
    .frame (frame),
    .st    (st),
    .cfg   (cfg),
    .dec   (dec)
  );

  assign out_free   = !m_tvalid || m_tready;
  assign final_beat = phase || (dec.n == 2'd1);
  assign load       = in_valid && (dec.n != 2'd0) && out_free;
  assign consume    = in_valid && ((dec.n == 2'd0) || (load && final_beat));
  assign s_tready   = !in_valid || consume;
  assign sel        = phase ? dec.res1 : dec.res0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      frame <= s_tdata[$bits(isotp_pkg::frame_t)-1:0];
    end
  end

  // second result of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (load) begin
      phase <= !final_beat;
    end
  end

  // receiver state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.receiving      <= 1'b0;
      st.total_length   <= '0;
      st.received_count <= '0;
      st.expected_seq   <= isotp_pkg::SEQ_START;
      st.retry_count    <= '0;
    end else if (consume) begin
      st <= dec.nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= sel;
    end
  end

  assign m_tdata = {res.bytes, res.byte_count, res.target_id};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

`ifndef ASSERT_OFF
  a_phase_needs_pair: assert property (@(posedge clk) disable iff (rst)
    phase |-> (in_valid && dec.n == 2'd2))
    else $error("second-result phase without a two-result frame");

  a_abort_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == isotp_pkg::KIND_ABORT) |-> (m_tdata == '0 && !m_tlast))
    else $error("abort beat carries payload");

  a_fc_layout: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == isotp_pkg::KIND_FC) |->
      (res.byte_count == isotp_pkg::FC_COUNT && res.bytes[0] == isotp_pkg::FC_STATUS
       && res.target_id == cfg.tx_id))
    else $error("malformed flow-control beat");

  a_idle_no_progress: assert property (@(posedge clk) disable iff (rst)
    (consume && !st.receiving && !dec.nxt.receiving) |=> (st.retry_count <= 16'hFFFF))
    else $error("retry count out of range");

  a_load_holds_pair: assert property (@(posedge clk) disable iff (rst)
    (load && !final_beat) |=> (in_valid && phase))
    else $error("frame dropped before its second result");
`endif

endmodule
